### design/etmm_pkg.sv
package etmm_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [30:0] Q30_ONE          = 31'h4000_0000;
    localparam logic [31:0] RAD_PER_UNIT_Q40 = 32'd299845282;
    localparam logic [31:0] ONE_FRAC         = 32'(64'd1 << FRAC_BITS);

    localparam logic [16:0] UNITS_OFFSET   = 17'd46080;
    localparam logic [16:0] UNITS_FULL     = 17'd23040;
    localparam logic [16:0] UNITS_FULL_X2  = 17'd46080;
    localparam logic [16:0] UNITS_FULL_X3  = 17'd69120;
    localparam logic [16:0] UNITS_QUARTER  = 17'd5760;
    localparam logic [16:0] UNITS_HALF     = 17'd11520;
    localparam logic [16:0] UNITS_3QUARTER = 17'd17280;
    localparam logic [12:0] UNITS_EIGHTH   = 13'd2880;

    localparam int NDIV = 9;
    localparam logic [3:0] K_SIN_LAST  = 4'd3;
    localparam logic [3:0] K_COS_FIRST = 4'd4;
    localparam logic [3:0] K_COS_LAST  = 4'd8;

    localparam logic [5:0] DIV_HALF [NDIV] = '{6'd36, 6'd21, 6'd10, 6'd3,
                                              6'd45, 6'd28, 6'd15, 6'd6, 6'd1};
    localparam logic [5:0] DIV_SHIFT [NDIV] = '{6'd38, 6'd37, 6'd36, 6'd34,
                                               6'd38, 6'd37, 6'd36, 6'd35, 6'd32};
    localparam logic [31:0] DIV_RECIP [NDIV] = '{
        32'(((64'd1 << 38) + 64'd71) / 64'd72),
        32'(((64'd1 << 37) + 64'd41) / 64'd42),
        32'(((64'd1 << 36) + 64'd19) / 64'd20),
        32'(((64'd1 << 34) + 64'd5) / 64'd6),
        32'(((64'd1 << 38) + 64'd89) / 64'd90),
        32'(((64'd1 << 37) + 64'd55) / 64'd56),
        32'(((64'd1 << 36) + 64'd29) / 64'd30),
        32'(((64'd1 << 35) + 64'd11) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

    localparam logic [4:0] STEP_SCALE = 5'd14;
    localparam logic [4:0] STEP_LAST  = 5'd22;
    localparam logic [1:0] SCALE_COL [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                             2'd2, 2'd2, 2'd2};
    localparam logic [1:0] SCALE_ROW [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                             2'd0, 2'd1, 2'd2};

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [1:0] LAST_COL  = 2'd3;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        logic [11:0] r;
        quad_t       quad;
        logic        fold;
    } ang_t;

    typedef struct packed {
        logic [2:0][31:0] trans;
        logic [2:0][31:0] scale;
        ang_t [2:0]       ang;
    } pose_t;

    typedef struct packed {
        logic [2:0][2:0][31:0] elem;
        logic [2:0][31:0]      trans;
    } mat_t;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_X_MUL,
        SC_X_WB,
        SC_X2_MUL,
        SC_X2_WB,
        SC_P_MUL,
        SC_P_WB,
        SC_D_MUL,
        SC_D_WB,
        SC_S_MUL,
        SC_S_WB,
        SC_DONE
    } sc_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_WAIT,
        BK_MUL,
        BK_WB,
        BK_HAND
    } bk_state_t;

    function automatic ang_t reduce_angle(input logic [15:0] a);
        logic [16:0] u;
        logic [16:0] r;
        ang_t        res;
        u = {a[15], a} + UNITS_OFFSET;
        if (u >= UNITS_FULL_X3) begin
            u = u - UNITS_FULL_X3;
        end else if (u >= UNITS_FULL_X2) begin
            u = u - UNITS_FULL_X2;
        end else if (u >= UNITS_FULL) begin
            u = u - UNITS_FULL;
        end
        if (u >= UNITS_3QUARTER) begin
            res.quad = QUAD_3;
            r = u - UNITS_3QUARTER;
        end else if (u >= UNITS_HALF) begin
            res.quad = QUAD_2;
            r = u - UNITS_HALF;
        end else if (u >= UNITS_QUARTER) begin
            res.quad = QUAD_1;
            r = u - UNITS_QUARTER;
        end else begin
            res.quad = QUAD_0;
            r = u;
        end
        if (r[12:0] > UNITS_EIGHTH) begin
            res.fold = 1'b1;
            res.r    = 12'(UNITS_QUARTER - r);
        end else begin
            res.fold = 1'b0;
            res.r    = r[11:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] res;
        if (v > 35'sh0_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### design/euler_trs_model_matrix.sv
// Pose to 4x4 model matrix, M = T * (Rz * Ry * Rx) * S, elements in Q16.16.
// Input channel s_axis: one request per pose. Output channel m_axis: four
// requests per pose, one matrix column each, column 0 first, tlast on column 3.
// The front stage reduces the three angles to an octant and queues the pose in a
// two-entry queue; the back sequencer evaluates sine and cosine of each angle on
// an iterative unit with one multiplier, then forms the rotation and the scaled
// columns on a second multiplier, via a multiply state and a write-back state.
// The back sequencer finishes one pose before it takes the next: it runs the
// sine/cosine iteration three times, then 23 products on the matrix multiplier.
// Up to two further poses are held (input register, queue) while one is worked
// on, and the finished matrix waits in the output register so the next pose
// proceeds while the receiver stalls; a stalled column holds its data.
// Reset (aresetn low, synchronous) empties all stages; no result is pending after.
module euler_trs_model_matrix (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // translation_x, translation_y, translation_z, angle_x, angle_y, angle_z,
    // scale_x, scale_y, scale_z
    input  logic [239:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // element_row0, element_row1, element_row2, element_row3
    output logic [127:0] m_axis_tdata,
    // column_index
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import etmm_pkg::*;

    logic  fr_valid, fr_ready;
    pose_t fr_pose;
    logic  q_valid, q_pop;
    pose_t q_pose;
    logic  mat_valid, mat_ready;
    mat_t  mat;

    etmm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .pose_valid    (fr_valid),
        .pose_ready    (fr_ready),
        .pose          (fr_pose)
    );

    etmm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_pose   (fr_pose),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_pose  (q_pose)
    );

    etmm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pose_valid (q_valid),
        .pose_pop   (q_pop),
        .pose       (q_pose),
        .mat_valid  (mat_valid),
        .mat_ready  (mat_ready),
        .mat        (mat)
    );

    etmm_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .mat_valid     (mat_valid),
        .mat_ready     (mat_ready),
        .mat           (mat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### design/etmm_sincos.sv
module etmm_sincos (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  etmm_pkg::ang_t      ang,
    output logic                done,
    output logic signed [31:0]  sin_out,
    output logic signed [31:0]  cos_out
);
    import etmm_pkg::*;

    sc_state_t   state_reg, state_next;
    ang_t        ang_reg, ang_next;
    logic [3:0]  k_reg, k_next;
    logic [30:0] x_reg, x_next;
    logic [30:0] x2_reg, x2_next;
    logic [30:0] t_reg, t_next;
    logic [30:0] n_reg, n_next;
    logic [30:0] s0_reg, s0_next;
    logic [63:0] prod_reg, prod_next;
    logic [30:0] rnd30;
    logic signed [31:0] s_base, c_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ang_reg  <= ang_next;
        k_reg    <= k_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        t_reg    <= t_next;
        n_reg    <= n_next;
        s0_reg   <= s0_next;
        prod_reg <= prod_next;
    end

    assign rnd30 = 31'((prod_reg + 64'd536870912) >> 30);

    always_comb begin
        state_next = state_reg;
        ang_next   = ang_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        s0_next    = s0_reg;
        prod_next  = prod_reg;
        case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    ang_next   = ang;
                    state_next = SC_X_MUL;
                end
            end
            SC_X_MUL: begin
                prod_next  = {20'd0, ang_reg.r} * {32'd0, RAD_PER_UNIT_Q40};
                state_next = SC_X_WB;
            end
            SC_X_WB: begin
                x_next     = 31'((prod_reg + 64'd512) >> 10);
                state_next = SC_X2_MUL;
            end
            SC_X2_MUL: begin
                prod_next  = {33'd0, x_reg} * {33'd0, x_reg};
                state_next = SC_X2_WB;
            end
            SC_X2_WB: begin
                x2_next    = rnd30;
                t_next     = Q30_ONE;
                k_next     = 4'd0;
                state_next = SC_P_MUL;
            end
            SC_P_MUL: begin
                prod_next  = {33'd0, x2_reg} * {33'd0, t_reg};
                state_next = SC_P_WB;
            end
            SC_P_WB: begin
                n_next     = rnd30 + {25'd0, DIV_HALF[k_reg]};
                state_next = SC_D_MUL;
            end
            SC_D_MUL: begin
                prod_next  = {33'd0, n_reg} * {32'd0, DIV_RECIP[k_reg]};
                state_next = SC_D_WB;
            end
            SC_D_WB: begin
                t_next = Q30_ONE - 31'(prod_reg >> DIV_SHIFT[k_reg]);
                if (k_reg == K_SIN_LAST) begin
                    state_next = SC_S_MUL;
                end else if (k_reg == K_COS_LAST) begin
                    state_next = SC_DONE;
                end else begin
                    k_next     = k_reg + 4'd1;
                    state_next = SC_P_MUL;
                end
            end
            SC_S_MUL: begin
                prod_next  = {33'd0, x_reg} * {33'd0, t_reg};
                state_next = SC_S_WB;
            end
            SC_S_WB: begin
                s0_next    = rnd30;
                t_next     = Q30_ONE;
                k_next     = K_COS_FIRST;
                state_next = SC_P_MUL;
            end
            SC_DONE: begin
                state_next = SC_IDLE;
            end
            default: begin
                state_next = SC_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == SC_DONE);
    assign s_base = ang_reg.fold ? $signed({1'b0, t_reg}) : $signed({1'b0, s0_reg});
    assign c_base = ang_reg.fold ? $signed({1'b0, s0_reg}) : $signed({1'b0, t_reg});

    always_comb begin
        case (ang_reg.quad)
            QUAD_0: begin
                sin_out = s_base;
                cos_out = c_base;
            end
            QUAD_1: begin
                sin_out = c_base;
                cos_out = -s_base;
            end
            QUAD_2: begin
                sin_out = -s_base;
                cos_out = -c_base;
            end
            default: begin
                sin_out = -c_base;
                cos_out = s_base;
            end
        endcase
    end

endmodule

### design/etmm_front.sv
module etmm_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [239:0]    s_axis_tdata,
    output logic            pose_valid,
    input  logic            pose_ready,
    output etmm_pkg::pose_t pose
);
    import etmm_pkg::*;

    logic  valid_reg, valid_next;
    pose_t pose_reg, pose_next;
    logic  take;

    assign s_axis_tready = !valid_reg || pose_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        pose_next  = pose_reg;
        if (pose_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next       = 1'b1;
            pose_next.trans  = s_axis_tdata[95:0];
            pose_next.ang[0] = reduce_angle(s_axis_tdata[111:96]);
            pose_next.ang[1] = reduce_angle(s_axis_tdata[127:112]);
            pose_next.ang[2] = reduce_angle(s_axis_tdata[143:128]);
            pose_next.scale  = s_axis_tdata[239:144];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        pose_reg <= pose_next;
    end

    assign pose_valid = valid_reg;
    assign pose       = pose_reg;

endmodule

### design/etmm_fifo.sv
module etmm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  etmm_pkg::pose_t in_pose,
    output logic            out_valid,
    input  logic            out_ready,
    output etmm_pkg::pose_t out_pose
);
    import etmm_pkg::*;

    pose_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_pose  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_pose;
        end
    end

endmodule

### design/etmm_back.sv
module etmm_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pose_valid,
    output logic            pose_pop,
    input  etmm_pkg::pose_t pose,
    output logic            mat_valid,
    input  logic            mat_ready,
    output etmm_pkg::mat_t  mat
);
    import etmm_pkg::*;

    bk_state_t          state_reg, state_next;
    logic [1:0]         axis_reg, axis_next;
    logic [4:0]         step_reg, step_next;
    logic [63:0]        prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] sn_reg [3];
    logic signed [31:0] cs_reg [3];
    logic signed [31:0] czsy_reg, szsy_reg;
    logic signed [34:0] tmp_reg;
    logic signed [33:0] rot_reg [3][3];
    logic [31:0]        elem_reg [3][3];

    logic               sc_start, sc_done;
    logic signed [31:0] sc_sin, sc_cos;
    logic signed [33:0] op_a, op_b;
    logic [33:0]        mag_a, mag_b;
    logic [3:0]         sk;
    logic [1:0]         s_col, s_row;
    logic [33:0]        rnd;
    logic signed [34:0] p;
    logic signed [35:0] p_sum, p_dif;

    etmm_sincos u_sincos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .ang     (pose.ang[axis_reg]),
        .done    (sc_done),
        .sin_out (sc_sin),
        .cos_out (sc_cos)
    );

    assign sk    = 4'(step_reg - STEP_SCALE);
    assign s_col = SCALE_COL[sk];
    assign s_row = SCALE_ROW[sk];

    always_comb begin
        case (step_reg)
            5'd0: begin op_a = 34'(cs_reg[2]); op_b = 34'(sn_reg[1]); end
            5'd1: begin op_a = 34'(sn_reg[2]); op_b = 34'(sn_reg[1]); end
            5'd2: begin op_a = 34'(cs_reg[2]); op_b = 34'(cs_reg[1]); end
            5'd3: begin op_a = 34'(sn_reg[2]); op_b = 34'(cs_reg[0]); end
            5'd4: begin op_a = 34'(czsy_reg);  op_b = 34'(sn_reg[0]); end
            5'd5: begin op_a = 34'(sn_reg[2]); op_b = 34'(sn_reg[0]); end
            5'd6: begin op_a = 34'(czsy_reg);  op_b = 34'(cs_reg[0]); end
            5'd7: begin op_a = 34'(sn_reg[2]); op_b = 34'(cs_reg[1]); end
            5'd8: begin op_a = 34'(cs_reg[2]); op_b = 34'(cs_reg[0]); end
            5'd9: begin op_a = 34'(szsy_reg);  op_b = 34'(sn_reg[0]); end
            5'd10: begin op_a = 34'(cs_reg[2]); op_b = 34'(sn_reg[0]); end
            5'd11: begin op_a = 34'(szsy_reg);  op_b = 34'(cs_reg[0]); end
            5'd12: begin op_a = 34'(cs_reg[1]); op_b = 34'(sn_reg[0]); end
            5'd13: begin op_a = 34'(cs_reg[1]); op_b = 34'(cs_reg[0]); end
            default: begin
                op_a = rot_reg[s_row][s_col];
                op_b = 34'($signed(pose.scale[s_col]));
            end
        endcase
    end

    assign mag_a = op_a[33] ? 34'(-op_a) : op_a;
    assign mag_b = op_b[33] ? 34'(-op_b) : op_b;
    assign rnd   = 34'((prod_reg + 64'd536870912) >> 30);
    assign p     = neg_reg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    assign p_sum = 36'(tmp_reg) + 36'(p);
    assign p_dif = 36'(tmp_reg) - 36'(p);

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        sc_start   = 1'b0;
        pose_pop   = 1'b0;
        mat_valid  = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (pose_valid) begin
                    axis_next  = 2'd0;
                    state_next = BK_START;
                end
            end
            BK_START: begin
                sc_start   = 1'b1;
                state_next = BK_WAIT;
            end
            BK_WAIT: begin
                if (sc_done) begin
                    if (axis_reg == AXIS_LAST) begin
                        step_next  = 5'd0;
                        state_next = BK_MUL;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = BK_START;
                    end
                end
            end
            BK_MUL: begin
                prod_next  = {32'd0, mag_a[31:0]} * {32'd0, mag_b[31:0]};
                neg_next   = op_a[33] ^ op_b[33];
                state_next = BK_WB;
            end
            BK_WB: begin
                if (step_reg == STEP_LAST) begin
                    state_next = BK_HAND;
                end else begin
                    step_next  = step_reg + 5'd1;
                    state_next = BK_MUL;
                end
            end
            BK_HAND: begin
                mat_valid = 1'b1;
                if (mat_ready) begin
                    pose_pop   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
        axis_reg <= axis_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        if (state_reg == BK_WAIT && sc_done) begin
            sn_reg[axis_reg] <= sc_sin;
            cs_reg[axis_reg] <= sc_cos;
            if (axis_reg == AXIS_LAST) begin
                rot_reg[2][0] <= -34'(sn_reg[1]);
            end
        end
        if (state_reg == BK_WB) begin
            case (step_reg)
                5'd0: czsy_reg <= p[31:0];
                5'd1: szsy_reg <= p[31:0];
                5'd2: rot_reg[0][0] <= p[33:0];
                5'd3: tmp_reg <= p;
                5'd4: rot_reg[0][1] <= p_dif[33:0];
                5'd5: tmp_reg <= p;
                5'd6: rot_reg[0][2] <= p_sum[33:0];
                5'd7: rot_reg[1][0] <= 34'(-p);
                5'd8: tmp_reg <= p;
                5'd9: rot_reg[1][1] <= p_sum[33:0];
                5'd10: tmp_reg <= p;
                5'd11: rot_reg[1][2] <= p_dif[33:0];
                5'd12: rot_reg[2][1] <= 34'(-p);
                5'd13: rot_reg[2][2] <= p[33:0];
                default: elem_reg[s_col][s_row] <= sat32(p);
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                mat.elem[c][r] = elem_reg[c][r];
            end
        end
        mat.trans = pose.trans;
    end

endmodule

### design/etmm_out.sv
module etmm_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           mat_valid,
    output logic           mat_ready,
    input  etmm_pkg::mat_t mat,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [127:0]   m_axis_tdata,
    output logic [1:0]     m_axis_tuser,
    output logic           m_axis_tlast
);
    import etmm_pkg::*;

    mat_t       mat_reg;
    logic       busy_reg;
    logic [1:0] col_reg;
    logic       send;

    assign send      = busy_reg && m_axis_tready;
    assign mat_ready = !busy_reg || (send && col_reg == LAST_COL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= 2'd0;
        end else if (mat_valid && mat_ready) begin
            busy_reg <= 1'b1;
            col_reg  <= 2'd0;
        end else if (send) begin
            if (col_reg == LAST_COL) begin
                busy_reg <= 1'b0;
            end
            col_reg <= col_reg + 2'd1;
        end
        if (mat_valid && mat_ready) begin
            mat_reg <= mat;
        end
    end

    always_comb begin
        case (col_reg)
            2'd0: m_axis_tdata = {32'd0, mat_reg.elem[0]};
            2'd1: m_axis_tdata = {32'd0, mat_reg.elem[1]};
            2'd2: m_axis_tdata = {32'd0, mat_reg.elem[2]};
            default: m_axis_tdata = {ONE_FRAC, mat_reg.trans};
        endcase
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tuser  = col_reg;
    assign m_axis_tlast  = (col_reg == LAST_COL);

endmodule
